FILE: src/opr_pkg.sv
package opr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int REFS_DEF      = 32;
  localparam int PAGE_BITS_DEF = 8;

  localparam int FC_W   = 4;
  localparam int POS_W  = 5;
  localparam int SLOT_W = 3;
  localparam int TOT_W  = 6;

  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 4'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_LOOK,
    ST_SCAN,
    ST_SEL
  } state_t;

  // Controls broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic clear;
    logic scan_clr;
    logic probe_valid;
  } cell_ctl_t;

endpackage

FILE: src/opr_ref_store.sv
module opr_ref_store #(
  parameter int PAGE_BITS = 8,
  parameter int REFS      = 32,
  parameter int AW        = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [PAGE_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [PAGE_BITS-1:0] rdata
);

  logic [PAGE_BITS-1:0] mem [REFS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/opr_cell.sv
module opr_cell import opr_pkg::*; #(
  parameter int PAGE_BITS = 8,
  parameter int PW        = 5,
  parameter int IW        = 3,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic                 active,
  input  logic                 we,
  input  logic [PAGE_BITS-1:0] wpage,
  input  logic [PAGE_BITS-1:0] probe_page,
  input  logic [PW-1:0]        probe_pos,
  input  logic                 in_valid,
  input  logic [PW:0]          in_key,
  input  logic [IW-1:0]        in_idx,
  output logic                 out_valid,
  output logic [PW:0]          out_key,
  output logic [IW-1:0]        out_idx,
  output logic                 valid,
  output logic [PAGE_BITS-1:0] page,
  output logic                 match
);

  logic          found;
  logic [PW-1:0] pos;
  logic [PW:0]   key;
  logic          take;

  assign match = valid && (page == probe_page);
  // A frame never referenced again ranks above every found position, and all such
  // frames rank equal so that the lowest slot keeps the tie.
  assign key   = {~found, {PW{found}} & pos};
  assign take  = active && (!in_valid || (key > in_key));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (we) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      page <= wpage;
    end
    if (rst || ctl.scan_clr) begin
      found <= 1'b0;
    end else if (ctl.probe_valid && match && !found) begin
      found <= 1'b1;
      pos   <= probe_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= take || in_valid;
    end
    out_key <= take ? key : in_key;
    out_idx <= take ? IW'(IDX) : in_idx;
  end

endmodule

FILE: src/optimal_page_replacement_unit.sv
// Channel   Direction  Handshake                     Payload
// command   in         start, busy                   page, last
// result    out        res_strobe (one cycle)        position, page_res, fault, slot,
//                                                    evicted_valid, evicted_page,
//                                                    fault_total, overflow, done_res
// config    in         cfg_valid, cfg_ready          cfg_data (frame_count)
//
// Loading accepts one reference per cycle; busy stays low while loading.
// The item marked last starts a replay: a setup state, then one hit or fill per cycle,
// held while a fault is resolved. A fault with all frames full spends its lookup
// state, scans the references after it (one per cycle through the store read port),
// then waits in the select state for the victim to ripple down the cell chain.
// Each result appears in the cycle after its reference is decided.
// Reset is synchronous; after reset the store is empty and frame_count is 3.
// The receiver cannot stall: each result transaction lasts exactly one cycle.
module optimal_page_replacement_unit import opr_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int REFS      = REFS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [FC_W-1:0]      cfg_data,
  output logic                 res_strobe,
  output logic [POS_W-1:0]     position,
  output logic [PAGE_BITS-1:0] page_res,
  output logic                 fault,
  output logic [SLOT_W-1:0]    slot,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [TOT_W-1:0]     fault_total,
  output logic                 overflow,
  output logic                 done_res
);

  localparam int PW   = $clog2(REFS);
  localparam int CNTW = $clog2(REFS + 1);
  localparam int FW   = $clog2(FRAMES + 1);
  localparam int IW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW   = (FW > FC_W) ? FW : FC_W;
  localparam int SELW = $clog2(FRAMES + 2);

  state_t state, state_next;

  logic [FC_W-1:0]      frame_count;
  logic [CNTW-1:0]      count;
  logic                 ovf;
  logic [CNTW-1:0]      idx;
  logic [CNTW-1:0]      scan_j;
  logic [SELW-1:0]      sel_cnt;
  logic [FW-1:0]        fill;
  logic [CNTW-1:0]      faults;
  logic [PAGE_BITS-1:0] cur_page;
  logic                 probe_valid;
  logic [PW-1:0]        probe_pos;

  logic [CW-1:0]        fc_ext;
  logic [FW-1:0]        nf;
  logic [PW-1:0]        rd_addr;
  logic [PAGE_BITS-1:0] rd_data;
  logic                 st_we;
  logic [CNTW-1:0]      idx_inc;
  logic                 is_final;

  logic                 emit, do_fill, do_evict, scan_start, probe_next;
  cell_ctl_t            ctl;
  logic                 hit;
  logic [IW-1:0]        hit_slot;
  logic [PAGE_BITS-1:0] emit_page;
  logic [PAGE_BITS-1:0] wpage;

  logic [FRAMES-1:0]    active, cell_we, match, cvalid, ch_valid;
  logic [PAGE_BITS-1:0] cpage    [FRAMES];
  logic [PW:0]          ch_key   [FRAMES];
  logic [IW-1:0]        ch_idx   [FRAMES];
  logic [IW-1:0]        victim;

  assign busy      = (state != ST_LOAD);
  assign cfg_ready = (state == ST_LOAD);

  // Out-of-range frame counts clamp: zero acts as one, above FRAMES as FRAMES.
  assign fc_ext = CW'(frame_count);
  always_comb begin
    if (fc_ext == '0) begin
      nf = FW'(1);
    end else if (fc_ext > CW'(FRAMES)) begin
      nf = FW'(FRAMES);
    end else begin
      nf = FW'(fc_ext);
    end
  end

  assign idx_inc  = idx + CNTW'(1);
  assign is_final = (idx_inc == count);
  assign st_we    = (state == ST_LOAD) && start && (count < CNTW'(REFS));
  assign victim   = ch_idx[FRAMES-1];

  always_comb begin
    unique case (state)
      ST_INIT: rd_addr = '0;
      ST_SCAN: rd_addr = scan_j[PW-1:0];
      default: rd_addr = idx_inc[PW-1:0];
    endcase
  end

  opr_ref_store #(
    .PAGE_BITS(PAGE_BITS),
    .REFS     (REFS),
    .AW       (PW)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(count[PW-1:0]),
    .wdata(page),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Hit detection across the frame cells; a page is resident in one frame at most.
  always_comb begin
    hit      = |match;
    hit_slot = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (match[k]) begin
        hit_slot = hit_slot | IW'(k);
      end
    end
  end

  assign emit_page = (state == ST_SEL) ? cur_page : rd_data;
  assign wpage     = do_fill ? rd_data : cur_page;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      assign active[g]  = (g < int'(nf));
      assign cell_we[g] = (do_fill && (fill == FW'(g))) || (do_evict && (victim == IW'(g)));

      if (g == 0) begin : g_head
        opr_cell #(.PAGE_BITS(PAGE_BITS), .PW(PW), .IW(IW), .IDX(g)) u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .active    (active[g]),
          .we        (cell_we[g]),
          .wpage     (wpage),
          .probe_page(rd_data),
          .probe_pos (probe_pos),
          .in_valid  (1'b0),
          .in_key    ('0),
          .in_idx    ('0),
          .out_valid (ch_valid[g]),
          .out_key   (ch_key[g]),
          .out_idx   (ch_idx[g]),
          .valid     (cvalid[g]),
          .page      (cpage[g]),
          .match     (match[g])
        );
      end else begin : g_body
        opr_cell #(.PAGE_BITS(PAGE_BITS), .PW(PW), .IW(IW), .IDX(g)) u_cell (
          .clk       (clk),
          .rst       (rst),
          .ctl       (ctl),
          .active    (active[g]),
          .we        (cell_we[g]),
          .wpage     (wpage),
          .probe_page(rd_data),
          .probe_pos (probe_pos),
          .in_valid  (ch_valid[g-1]),
          .in_key    (ch_key[g-1]),
          .in_idx    (ch_idx[g-1]),
          .out_valid (ch_valid[g]),
          .out_key   (ch_key[g]),
          .out_idx   (ch_idx[g]),
          .valid     (cvalid[g]),
          .page      (cpage[g]),
          .match     (match[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: load, set up the replay, then serve each reference in turn.
  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    do_fill         = 1'b0;
    do_evict        = 1'b0;
    scan_start      = 1'b0;
    probe_next      = 1'b0;
    ctl.clear       = 1'b0;
    ctl.scan_clr    = 1'b0;
    ctl.probe_valid = probe_valid;
    unique case (state)
      ST_LOAD: begin
        if (start && last) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        ctl.clear  = 1'b1;
        state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (hit) begin
          emit = 1'b1;
        end else if (fill < nf) begin
          emit    = 1'b1;
          do_fill = 1'b1;
        end else begin
          scan_start   = 1'b1;
          ctl.scan_clr = 1'b1;
          state_next   = ST_SCAN;
        end
        if (emit && is_final) begin
          state_next = ST_LOAD;
        end
      end
      ST_SCAN: begin
        if (scan_j < count) begin
          probe_next = 1'b1;
        end else begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        if (sel_cnt == SELW'(FRAMES + 1)) begin
          emit       = 1'b1;
          do_evict   = 1'b1;
          state_next = is_final ? ST_LOAD : ST_LOOK;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
      count       <= '0;
      ovf         <= 1'b0;
      probe_valid <= 1'b0;
      res_strobe  <= 1'b0;
      idx         <= '0;
      fill        <= '0;
      faults      <= '0;
    end else begin
      probe_valid <= probe_next;
      res_strobe  <= emit;
      if (cfg_valid && cfg_ready) begin
        frame_count <= cfg_data;
      end
      if (state == ST_LOAD && start) begin
        if (st_we) begin
          count <= count + CNTW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (state == ST_INIT) begin
        idx    <= '0;
        fill   <= '0;
        faults <= '0;
      end
      if (do_fill) begin
        fill <= fill + FW'(1);
      end
      if (emit) begin
        idx <= idx_inc;
        if (!(state == ST_LOOK && hit)) begin
          faults <= faults + CNTW'(1);
        end
        if (is_final) begin
          count <= '0;
          ovf   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      cur_page <= rd_data;
      scan_j   <= idx_inc;
    end
    if (probe_next) begin
      probe_pos <= scan_j[PW-1:0];
      scan_j    <= scan_j + CNTW'(1);
    end
    if (state == ST_SCAN) begin
      sel_cnt <= '0;
    end else if (state == ST_SEL) begin
      sel_cnt <= sel_cnt + SELW'(1);
    end
    if (emit) begin
      position      <= POS_W'(idx);
      page_res      <= emit_page;
      fault         <= !(state == ST_LOOK && hit);
      evicted_valid <= do_evict;
      evicted_page  <= do_evict ? cpage[victim] : '0;
      overflow      <= ovf;
      done_res      <= is_final;
      if (state == ST_LOOK && hit) begin
        slot        <= SLOT_W'(hit_slot);
        fault_total <= TOT_W'(faults);
      end else begin
        slot        <= do_fill ? SLOT_W'(fill) : SLOT_W'(victim);
        fault_total <= TOT_W'(faults + CNTW'(1));
      end
    end
  end

`ifndef SYNTHESIS
  // The last result of a replay coincides with the return to loading.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && done_res) |-> !busy)
    else $error("final result seen while still busy");

  // An eviction is always a fault.
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    (res_strobe && evicted_valid) |-> fault)
    else $error("eviction reported on a hit");

  // Victim selection only ever happens with every frame in use.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    do_evict |-> (fill == nf))
    else $error("eviction with an empty frame left");

  // The victim has reached the end of the chain when it is used.
  a_chain_ready: assert property (@(posedge clk) disable iff (rst)
    do_evict |-> ch_valid[FRAMES-1])
    else $error("victim used before the chain settled");

  // During a replay only frames in use hold a page.
  a_inactive_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> ((cvalid & ~active) == '0))
    else $error("page held in a frame beyond the frame count");
`endif

endmodule

FILE: tb/opr_replay_checker.sv
module opr_replay_checker import opr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [PAGE_BITS_DEF-1:0] page,
  input  logic                     last,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [FC_W-1:0]          cfg_data,
  input  logic                     res_strobe,
  input  logic [POS_W-1:0]         position,
  input  logic [PAGE_BITS_DEF-1:0] page_res,
  input  logic                     fault,
  input  logic [SLOT_W-1:0]        slot,
  input  logic                     evicted_valid,
  input  logic [PAGE_BITS_DEF-1:0] evicted_page,
  input  logic [TOT_W-1:0]         fault_total,
  input  logic                     overflow,
  input  logic                     done_res,
  output int                       fail_count,
  output int                       pending,
  output int                       checked,
  output int                       replays,
  output int                       overflows
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic [PAGE_BITS_DEF-1:0] page_res;
    logic                     fault;
    logic [SLOT_W-1:0]        slot;
    logic                     evicted_valid;
    logic [PAGE_BITS_DEF-1:0] evicted_page;
    logic [TOT_W-1:0]         fault_total;
    logic                     overflow;
    logic                     done_res;
  } ref_result_t;

  ref_result_t              expected_refs[$];
  logic [PAGE_BITS_DEF-1:0] loaded_pages[REFS_DEF];
  int                       ref_len;
  logic                     dropped;
  logic [FC_W-1:0]          frames_cfg;

  // Index of the next reference to pg at or after from; past the end if none.
  function automatic int next_ref(logic [PAGE_BITS_DEF-1:0] pg, int from);
    for (int j = from; j < ref_len; j++) begin
      if (loaded_pages[j] == pg) return j;
    end
    return REFS_DEF + 1;
  endfunction

  // Replays the stored string with Belady's rule and queues one result per reference.
  function automatic void replay_optimal();
    int                       nf;
    int                       fill;
    int                       faults;
    int                       best;
    int                       best_dist;
    int                       d;
    bit                       hit;
    bit                       fv[FRAMES_DEF];
    logic [PAGE_BITS_DEF-1:0] fp[FRAMES_DEF];
    ref_result_t              r;
    nf = (frames_cfg < 1) ? 1 : (frames_cfg > FRAMES_DEF) ? FRAMES_DEF : int'(frames_cfg);
    fill = 0;
    faults = 0;
    for (int k = 0; k < FRAMES_DEF; k++) begin
      fv[k] = 0;
      fp[k] = '0;
    end
    for (int i = 0; i < ref_len; i++) begin
      r = '0;
      r.position = i[POS_W-1:0];
      r.page_res = loaded_pages[i];
      hit = 0;
      for (int k = 0; k < nf; k++) begin
        if (!hit && fv[k] && fp[k] == loaded_pages[i]) begin
          hit = 1;
          r.slot = k[SLOT_W-1:0];
        end
      end
      if (!hit) begin
        if (fill < nf) begin
          r.slot = fill[SLOT_W-1:0];
          fill++;
        end else begin
          best = 0;
          best_dist = 0;
          for (int k = 0; k < nf; k++) begin
            d = next_ref(fp[k], i + 1);
            if (k == 0 || d > best_dist) begin
              best = k;
              best_dist = d;
            end
          end
          r.slot = best[SLOT_W-1:0];
          r.evicted_valid = 1;
          r.evicted_page = fp[best];
        end
        fv[r.slot] = 1;
        fp[r.slot] = loaded_pages[i];
        faults++;
      end
      r.fault = !hit;
      r.fault_total = faults[TOT_W-1:0];
      r.overflow = dropped;
      r.done_res = (i + 1 == ref_len);
      expected_refs.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    ref_result_t got;
    ref_result_t want;
    if (rst) begin
      expected_refs.delete();
      ref_len = 0;
      dropped = 0;
      frames_cfg = FRAME_COUNT_RST;
      fail_count = 0;
      checked = 0;
      replays = 0;
      overflows = 0;
    end else begin
      if (res_strobe) begin
        got = {position, page_res, fault, slot, evicted_valid, evicted_page,
               fault_total, overflow, done_res};
        if (expected_refs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing expected: pos %0d page %0d",
                     $time, position, page_res);
        end else begin
          want = expected_refs.pop_front();
          checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch pos/page/fault/slot/ev/evpage/total/ovf/done ",
                        "exp %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d ",
                        "got %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d"}, $time,
                       want.position, want.page_res, want.fault, want.slot,
                       want.evicted_valid, want.evicted_page, want.fault_total,
                       want.overflow, want.done_res,
                       got.position, got.page_res, got.fault, got.slot,
                       got.evicted_valid, got.evicted_page, got.fault_total,
                       got.overflow, got.done_res);
          end
        end
      end
      if (cfg_valid && cfg_ready) frames_cfg = cfg_data;
      if (start && !busy) begin
        if (ref_len < REFS_DEF) begin
          loaded_pages[ref_len] = page;
          ref_len++;
        end else begin
          dropped = 1;
        end
        if (last) begin
          if (dropped) overflows++;
          replays++;
          replay_optimal();
          ref_len = 0;
          dropped = 0;
        end
      end
    end
    pending = expected_refs.size();
  end

endmodule

FILE: tb/tb_optimal_page_replacement_unit.sv
module tb_optimal_page_replacement_unit;
  import opr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Once every predicted result is back the block is idle again; these extra quiet
  // cycles only spread the register writes apart from the last string.
  localparam int SETTLE_CYCLES = 80;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [PAGE_BITS_DEF-1:0] page;
  logic                     last;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [FC_W-1:0]          cfg_data;
  logic                     res_strobe;
  logic [POS_W-1:0]         position;
  logic [PAGE_BITS_DEF-1:0] page_res;
  logic                     fault;
  logic [SLOT_W-1:0]        slot;
  logic                     evicted_valid;
  logic [PAGE_BITS_DEF-1:0] evicted_page;
  logic [TOT_W-1:0]         fault_total;
  logic                     overflow;
  logic                     done_res;

  int fail_count;
  int pending;
  int checked;
  int replays;
  int overflows;
  int sent;
  bit no_gaps;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  optimal_page_replacement_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .page(page), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .res_strobe(res_strobe), .position(position), .page_res(page_res),
    .fault(fault), .slot(slot), .evicted_valid(evicted_valid),
    .evicted_page(evicted_page), .fault_total(fault_total),
    .overflow(overflow), .done_res(done_res)
  );

  // The checker sees every transaction on all three channels and predicts on its own.
  opr_replay_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .page(page), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .res_strobe(res_strobe), .position(position), .page_res(page_res),
    .fault(fault), .slot(slot), .evicted_valid(evicted_valid),
    .evicted_page(evicted_page), .fault_total(fault_total),
    .overflow(overflow), .done_res(done_res),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .replays(replays), .overflows(overflows)
  );

  // Mostly back-to-back or short pauses, with the occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Presents one reference at a falling edge and holds it until the block takes it.
  // Start is lowered only when a pause follows, so it is never lowered and raised
  // in the same time step.
  task automatic send_ref(input logic [PAGE_BITS_DEF-1:0] pg, input logic is_last);
    int gap;
    start <= 1'b1;
    page  <= pg;
    last  <= is_last;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Waits until every predicted result has come back, then stays quiet a while.
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_frames(input logic [FC_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(0, 3)) @(negedge clk);
  endtask

  // A random reference string. Most draw from a small pool of pages so that hits
  // and evictions happen often; some use the full page range.
  task automatic send_string(input int len);
    int pool;
    int base;
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    pool = $urandom_range(1, 12);
    base = $urandom_range(0, 255 - pool);
    for (int i = 0; i < len; i++) begin
      if (wide) send_ref(8'($urandom_range(0, 255)), i == len - 1);
      else send_ref(8'(base + $urandom_range(0, pool)), i == len - 1);
    end
  endtask

  initial begin
    int len;
    rst = 1'b1;
    start = 1'b0;
    page = '0;
    last = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sent = 0;
    no_gaps = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A one-reference string at the reset frame count, then the page
    // extremes, then a single frame so every miss after the first evicts.
    send_ref(8'd0, 1'b1);
    send_ref(8'd255, 1'b0);
    send_ref(8'd0, 1'b0);
    send_ref(8'd255, 1'b0);
    send_ref(8'd170, 1'b0);
    send_ref(8'd85, 1'b1);
    write_frames(4'd1);
    send_ref(8'd1, 1'b0);
    send_ref(8'd2, 1'b0);
    send_ref(8'd1, 1'b0);
    send_ref(8'd1, 1'b1);
    // Zero frames behaves like one frame.
    write_frames(4'd0);
    send_ref(8'd7, 1'b0);
    send_ref(8'd8, 1'b1);
    // Eight frames: fills only, then a hit on the last slot.
    write_frames(4'd8);
    for (int i = 0; i < 8; i++) send_ref(8'(i * 17), 1'b0);
    send_ref(8'd119, 1'b1);
    // Values past eight saturate; a tie among pages never used again goes to slot 0.
    write_frames(4'd15);
    send_ref(8'd3, 1'b1);
    write_frames(4'd2);
    send_ref(8'd4, 1'b0);
    send_ref(8'd5, 1'b0);
    send_ref(8'd6, 1'b1);

    // Random part: whole strings with random content, a few running past the store
    // so that references are dropped, with the frame count changed now and then.
    while (sent < 470) begin
      if ($urandom_range(0, 3) == 0) write_frames(4'($urandom_range(0, 15)));
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) len = $urandom_range(REFS_DEF + 1, REFS_DEF + 6);
      else if ($urandom_range(0, 5) == 0) len = REFS_DEF;
      else len = $urandom_range(1, 20);
      send_string(len);
    end
    no_gaps = 0;
    drain();

    $display("Covered %0d references in %0d strings, %0d with dropped references;",
             sent, replays, overflows);
    $display("%0d replay results compared, %0d failures.", checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
